// ===== hdl/stl_pkg.sv =====
// Shared types, character codes and byte classes for the script token lexer.
// No dependencies; every other file of the block except hdl/stl_if.sv imports this package.
package stl_pkg;

	localparam int OFFSET_BITS = 32;
	localparam int LINE_BITS   = 24;
	localparam int COUNT_BITS  = 32;
	localparam int FIELD_BITS  = 32;
	localparam int MAX_RESULTS = 3;

	typedef enum logic [4:0] {
		M_START, M_COMMENT, M_SPACE, M_INT, M_FRAC, M_BIN, M_STR, M_STR_ESC,
		M_BYTES, M_CH_OPEN, M_CH_ESC, M_CH_GOT, M_WORD
	} mode_t;

	typedef enum logic [3:0] {
		K_COMMENT, K_NEWLINE, K_SPACE, K_INT, K_FLOAT, K_BINARY, K_STRING,
		K_BYTESTR, K_CHAR, K_COMMA, K_WORD, K_ERROR, K_END
	} kind_t;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_BANG  = 8'h21;
	localparam logic [7:0] CH_DQ    = 8'h22;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_PCT   = 8'h25;
	localparam logic [7:0] CH_SQ    = 8'h27;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_ONE   = 8'h31;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_LBR   = 8'h5B;
	localparam logic [7:0] CH_BSL   = 8'h5C;
	localparam logic [7:0] CH_RBR   = 8'h5D;
	localparam logic [7:0] CH_US    = 8'h5F;

	// One lexing decision on the current window
	typedef struct packed {
		logic       need;
		logic [1:0] take;
		logic       emit;
		kind_t      kind;
		mode_t      mode_nx;
		logic       line_inc;
		logic       is_start;
		logic       is_end;
	} dec_t;

	typedef struct packed {
		kind_t                  kind;
		logic [FIELD_BITS-1:0]  start;
		logic [FIELD_BITS-1:0]  length;
		logic [LINE_BITS-1:0]   line;
		logic [COUNT_BITS-1:0]  number;
		logic                   last;
	} tok_t;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
	endfunction

	function automatic logic is_word_tail(input logic [7:0] c);
		return is_alpha(c) || is_digit(c) || (c == CH_US) || (c == CH_MINUS) ||
			(c == CH_COLON) || (c == CH_PLUS) || (c == CH_HASH) || (c == CH_BANG) ||
			(c == CH_STAR);
	endfunction

endpackage

// ===== hdl/stl_if.sv =====
// Valid/ready channel interfaces for script bytes in and tokens out.
// Standalone; widths follow the field widths of the block.
interface stl_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink (input valid, input in_byte, output ready);
endinterface

interface stl_token_if;
	logic        valid;
	logic        ready;
	logic [3:0]  token_kind;
	logic [31:0] token_start;
	logic [31:0] token_length;
	logic [23:0] token_line;
	logic [31:0] token_number;
	logic        last_of_run;

	modport source (output valid, output token_kind, output token_start,
		output token_length, output token_line, output token_number,
		output last_of_run, input ready);
	modport sink (input valid, input token_kind, input token_start,
		input token_length, input token_line, input token_number,
		input last_of_run, output ready);
endinterface

// ===== hdl/stl_decide.sv =====
// Classifier for one lexing step: looks at the mode and a window of up to
// three bytes and returns what to take, emit and switch to. Uses stl_pkg.
module stl_decide (
	input  stl_pkg::mode_t      mode,
	input  logic [2:0][7:0]     win,
	input  logic [1:0]          n,
	output stl_pkg::dec_t       dec
);
	import stl_pkg::*;

	logic [7:0] c, c1, c2;

	assign c  = win[0];
	assign c1 = win[1];
	assign c2 = win[2];

	// Decide on the head byte, using lookahead where the token needs it
	always_comb begin
		dec = '{need: 1'b0, take: 2'd0, emit: 1'b0, kind: K_ERROR, mode_nx: mode,
			line_inc: 1'b0, is_start: 1'b0, is_end: 1'b0};
		case (mode)
			M_START: begin
				dec.is_start = 1'b1;
				if (c == CH_NUL) begin
					dec.emit = 1'b1; dec.kind = K_END; dec.is_end = 1'b1;
					dec.mode_nx = M_START;
				end else if (c == CH_STAR) begin
					dec.take = 2'd1; dec.mode_nx = M_COMMENT;
				end else if (c == CH_LF) begin
					dec.take = 2'd1; dec.line_inc = 1'b1;
					dec.emit = 1'b1; dec.kind = K_NEWLINE;
				end else if (c == CH_CR) begin
					if (n < 2'd2) dec.need = 1'b1;
					else if (c1 == CH_LF) begin
						dec.take = 2'd2; dec.line_inc = 1'b1;
						dec.emit = 1'b1; dec.kind = K_NEWLINE;
					end else begin
						dec.take = 2'd1; dec.mode_nx = M_SPACE;
					end
				end else if (c == CH_SP || c == CH_TAB) begin
					dec.take = 2'd1; dec.mode_nx = M_SPACE;
				end else if (c == CH_DOT) begin
					if (n < 2'd2) dec.need = 1'b1;
					else if (is_digit(c1)) begin
						dec.take = 2'd2; dec.mode_nx = M_FRAC;
					end else begin
						dec.take = 2'd1; dec.emit = 1'b1; dec.kind = K_ERROR;
					end
				end else if (c == CH_MINUS) begin
					if (n < 2'd2) dec.need = 1'b1;
					else if (c1 == CH_DOT) begin
						if (n < 2'd3) dec.need = 1'b1;
						else if (is_digit(c2)) begin
							dec.take = 2'd3; dec.mode_nx = M_FRAC;
						end else begin
							dec.take = 2'd1; dec.emit = 1'b1; dec.kind = K_ERROR;
						end
					end else if (is_digit(c1)) begin
						dec.take = 2'd1; dec.mode_nx = M_INT;
					end else begin
						dec.take = 2'd1; dec.emit = 1'b1; dec.kind = K_ERROR;
					end
				end else if (is_digit(c)) begin
					if (n < 2'd2) dec.need = 1'b1;
					else begin
						dec.take = 2'd1;
						if (!is_alpha(c1)) dec.mode_nx = M_INT;
						else begin
							dec.emit = 1'b1; dec.kind = K_ERROR;
						end
					end
				end else if (c == CH_PCT) begin
					if (n < 2'd2) dec.need = 1'b1;
					else begin
						dec.take = 2'd1;
						if (c1 == CH_ZERO || c1 == CH_ONE) dec.mode_nx = M_BIN;
						else begin
							dec.emit = 1'b1; dec.kind = K_ERROR;
						end
					end
				end else if (c == CH_DQ) begin
					dec.take = 2'd1; dec.mode_nx = M_STR;
				end else if (c == CH_LBR) begin
					dec.take = 2'd1; dec.mode_nx = M_BYTES;
				end else if (c == CH_SQ) begin
					dec.take = 2'd1; dec.mode_nx = M_CH_OPEN;
				end else if (c == CH_COMMA) begin
					dec.take = 2'd1; dec.emit = 1'b1; dec.kind = K_COMMA;
				end else if (c == CH_LT || c == CH_GT) begin
					if (n < 2'd2) dec.need = 1'b1;
					else begin
						if (c1 == CH_EQ || (c == CH_LT && c1 == CH_GT)) dec.take = 2'd2;
						else dec.take = 2'd1;
						dec.emit = 1'b1; dec.kind = K_WORD;
					end
				end else if (c == CH_EQ) begin
					dec.take = 2'd1; dec.emit = 1'b1; dec.kind = K_WORD;
				end else if (is_alpha(c)) begin
					dec.take = 2'd1; dec.mode_nx = M_WORD;
				end else if (c == CH_US) begin
					if (n < 2'd2) dec.need = 1'b1;
					else begin
						dec.take = 2'd1;
						if (is_alpha(c1)) dec.mode_nx = M_WORD;
						else begin
							dec.emit = 1'b1; dec.kind = K_ERROR;
						end
					end
				end else begin
					dec.take = 2'd1; dec.emit = 1'b1; dec.kind = K_ERROR;
				end
			end
			M_COMMENT: begin
				if (c == CH_NUL || c == CH_LF) begin
					dec.emit = 1'b1; dec.kind = K_COMMENT;
				end else if (c == CH_CR) begin
					if (n < 2'd2) dec.need = 1'b1;
					else if (c1 == CH_LF) begin
						dec.emit = 1'b1; dec.kind = K_COMMENT;
					end else dec.take = 2'd1;
				end else dec.take = 2'd1;
			end
			M_SPACE: begin
				if (c == CH_SP || c == CH_TAB) dec.take = 2'd1;
				else if (c == CH_CR) begin
					if (n < 2'd2) dec.need = 1'b1;
					else if (c1 != CH_LF) dec.take = 2'd1;
					else begin
						dec.emit = 1'b1; dec.kind = K_SPACE;
					end
				end else begin
					dec.emit = 1'b1; dec.kind = K_SPACE;
				end
			end
			M_INT: begin
				if (is_digit(c)) dec.take = 2'd1;
				else if (c == CH_DOT) begin
					dec.take = 2'd1; dec.mode_nx = M_FRAC;
				end else begin
					dec.emit = 1'b1; dec.kind = K_INT;
				end
			end
			M_FRAC: begin
				if (is_digit(c)) dec.take = 2'd1;
				else begin
					dec.emit = 1'b1; dec.kind = K_FLOAT;
				end
			end
			M_BIN: begin
				if (c == CH_ZERO || c == CH_ONE) dec.take = 2'd1;
				else begin
					dec.emit = 1'b1; dec.kind = K_BINARY;
				end
			end
			M_STR: begin
				if (c == CH_NUL || c == CH_CR || c == CH_LF) begin
					dec.emit = 1'b1; dec.kind = K_ERROR;
				end else if (c == CH_BSL) begin
					dec.take = 2'd1; dec.mode_nx = M_STR_ESC;
				end else if (c == CH_DQ) begin
					dec.take = 2'd1; dec.emit = 1'b1; dec.kind = K_STRING;
				end else dec.take = 2'd1;
			end
			M_STR_ESC: begin
				if (c == CH_NUL) begin
					dec.emit = 1'b1; dec.kind = K_ERROR;
				end else begin
					dec.take = 2'd1; dec.mode_nx = M_STR;
				end
			end
			M_BYTES: begin
				if (c == CH_NUL) begin
					dec.emit = 1'b1; dec.kind = K_ERROR;
				end else if (c == CH_CR || c == CH_LF) begin
					dec.take = 2'd1; dec.emit = 1'b1; dec.kind = K_ERROR;
				end else if (c == CH_RBR) begin
					dec.take = 2'd1; dec.emit = 1'b1; dec.kind = K_BYTESTR;
				end else dec.take = 2'd1;
			end
			M_CH_OPEN: begin
				if (c == CH_BSL) begin
					dec.take = 2'd1; dec.mode_nx = M_CH_ESC;
				end else if (c == CH_NUL) begin
					dec.emit = 1'b1; dec.kind = K_ERROR;
				end else begin
					dec.take = 2'd1; dec.mode_nx = M_CH_GOT;
				end
			end
			M_CH_ESC: begin
				if (c == CH_NUL) begin
					dec.emit = 1'b1; dec.kind = K_ERROR;
				end else begin
					dec.take = 2'd1; dec.mode_nx = M_CH_GOT;
				end
			end
			M_CH_GOT: begin
				if (c == CH_NUL) begin
					dec.emit = 1'b1; dec.kind = K_ERROR;
				end else if (c == CH_SQ) begin
					dec.take = 2'd1; dec.emit = 1'b1; dec.kind = K_CHAR;
				end else begin
					dec.take = 2'd1; dec.emit = 1'b1; dec.kind = K_ERROR;
				end
			end
			M_WORD: begin
				if (is_word_tail(c)) dec.take = 2'd1;
				else begin
					dec.emit = 1'b1; dec.kind = K_WORD;
				end
			end
			default: dec.mode_nx = M_START;
		endcase
		// Any emit returns to the start of a token
		if (dec.emit) dec.mode_nx = M_START;
	end

endmodule

// ===== hdl/script_token_lexer_core.sv =====
// Top level of the script token lexer: byte window, counters, one lexing
// decision per cycle (unless the byte input or a full output path stalls it)
// and a two-entry token output path. Uses stl_pkg, stl_if and stl_decide.
// A token passes from the decision that ends it to a holding slot, which
// resolves the last-of-run flag, and then to the output register.
// A new byte is accepted only after the decisions on the previous byte end.
// Reset (arst_n low, asynchronous): start-of-token mode, empty lookahead,
// offsets 0, line 1, token count 0, no token pending.
module script_token_lexer_core (
	input  logic           clk,
	input  logic           arst_n,
	stl_byte_if.sink       byte_in,
	stl_token_if.source    token_out
);
	import stl_pkg::*;

	localparam logic [OFFSET_BITS-1:0] OMAX = {OFFSET_BITS{1'b1}};
	localparam logic [LINE_BITS-1:0]   LMAX = {LINE_BITS{1'b1}};
	localparam logic [COUNT_BITS-1:0]  CMAX = {COUNT_BITS{1'b1}};

	mode_t                  mode_q;
	logic [2:0][7:0]        win_q;
	logic [1:0]             wn_q;
	logic                   active_q;
	logic [1:0]             nout_q;
	logic [OFFSET_BITS-1:0] off_q, start_q;
	logic [LINE_BITS-1:0]   line_q, sline_q;
	logic [COUNT_BITS-1:0]  tcount_q;
	logic                   pend_v_q, out_v_q;
	tok_t                   pend_q, out_q;

	logic [2:0][7:0]        ewin, win_sh;
	logic [1:0]             wn_e, wn_t, k;
	dec_t                   d;
	logic                   out_free, can_emit, go, step_end, pend_move, do_start;
	logic [OFFSET_BITS:0]   off_sum;
	logic [OFFSET_BITS-1:0] off_sat, off_nx, e_start;
	logic [LINE_BITS-1:0]   e_line;
	logic [1:0]             nout_base;
	logic [2:0]             nout_sum;
	tok_t                   tok_new;

	// Build the working window: stored lookahead plus the offered byte
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (!active_q && (2'(i) == wn_q)) ewin[i] = byte_in.in_byte;
			else ewin[i] = win_q[i];
		end
		wn_e = active_q ? wn_q : wn_q + 2'd1;
	end

	stl_decide u_decide (
		.mode (mode_q),
		.win  (ewin),
		.n    (wn_e),
		.dec  (d)
	);

	// Handshake and stall conditions
	assign out_free = !out_v_q || token_out.ready;
	assign can_emit = !pend_v_q || out_free;
	assign byte_in.ready = !active_q && can_emit;
	assign go = active_q ? (!d.emit || can_emit) : (byte_in.valid && can_emit);

	// Consume bytes and advance the saturating offset
	assign k        = d.need ? 2'd0 : d.take;
	assign do_start = d.is_start && !d.need;
	assign off_sum  = {1'b0, off_q} + (OFFSET_BITS + 1)'(k);
	assign off_sat  = (off_sum > {1'b0, OMAX}) ? OMAX : off_sum[OFFSET_BITS-1:0];
	assign off_nx   = d.is_end ? '0 : off_sat;
	assign e_start  = do_start ? off_q : start_q;
	assign e_line   = do_start ? line_q : sline_q;

	always_comb begin
		logic [2:0] idx;
		for (int i = 0; i < 3; i++) begin
			idx = 3'(i) + {1'b0, k};
			win_sh[i] = (idx < 3'd3) ? ewin[idx[1:0]] : 8'h00;
		end
	end

	assign wn_t      = d.is_end ? 2'd0 : wn_e - k;
	assign nout_base = active_q ? nout_q : 2'd0;
	assign nout_sum  = {1'b0, nout_base} + {2'b0, d.emit};
	assign step_end  = d.need || (wn_t == 2'd0) || (nout_sum == 3'(MAX_RESULTS));

	// Form the token released by this decision
	always_comb begin
		tok_new.kind   = d.kind;
		tok_new.start  = FIELD_BITS'(e_start);
		tok_new.length = d.is_end ? '0 : FIELD_BITS'(off_sat - e_start);
		tok_new.line   = e_line;
		tok_new.number = tcount_q;
		tok_new.last   = step_end;
	end

	assign pend_move = pend_v_q && out_free && (pend_q.last || (go && d.emit));

	// Advance lexer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= M_START;
			win_q    <= '0;
			wn_q     <= 2'd0;
			active_q <= 1'b0;
			nout_q   <= 2'd0;
			off_q    <= '0;
			start_q  <= '0;
			line_q   <= LINE_BITS'(1);
			sline_q  <= LINE_BITS'(1);
			tcount_q <= '0;
		end else if (go) begin
			mode_q   <= d.mode_nx;
			win_q    <= win_sh;
			wn_q     <= (step_end && wn_t == 2'd3) ? 2'd2 : wn_t;
			active_q <= !step_end;
			nout_q   <= nout_sum[1:0];
			off_q    <= off_nx;
			if (d.is_end) begin
				start_q  <= '0;
				sline_q  <= LINE_BITS'(1);
				line_q   <= LINE_BITS'(1);
				tcount_q <= '0;
			end else begin
				if (do_start) begin
					start_q <= off_q;
					sline_q <= line_q;
				end
				if (d.line_inc && line_q != LMAX) line_q <= line_q + LINE_BITS'(1);
				if (d.emit && tcount_q != CMAX) tcount_q <= tcount_q + COUNT_BITS'(1);
			end
		end
	end

	// Hold the newest token until the run's last flag is known
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
		end else if (go && d.emit) begin
			pend_v_q <= 1'b1;
		end else if (pend_move) begin
			pend_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go && d.emit) pend_q <= tok_new;
		else if (go && step_end && pend_v_q) pend_q.last <= 1'b1;
	end

	// Output register; transfer when the sink is ready
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (pend_move) begin
			out_v_q <= 1'b1;
		end else if (token_out.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pend_move) out_q <= pend_q;
	end

	assign token_out.valid        = out_v_q;
	assign token_out.token_kind   = out_q.kind;
	assign token_out.token_start  = out_q.start;
	assign token_out.token_length = out_q.length;
	assign token_out.token_line   = out_q.line;
	assign token_out.token_number = out_q.number;
	assign token_out.last_of_run  = out_q.last;

`ifndef NO_ASSERTIONS
	a_active_window: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> (wn_q != 2'd0))
		else $error("step in progress with an empty window");
	a_pend_open: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_v_q && !pend_q.last) |-> active_q)
		else $error("unfinished run held after its step ended");
	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && out_q.kind == K_END) |-> (out_q.last && out_q.length == '0))
		else $error("end token not last of run or has length");
	a_nout_bound: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> (nout_q != 2'd3))
		else $error("step continued past three tokens");
`endif

endmodule

// ===== dv/script_token_lexer_core_tb_if.sv =====
// Interfaces used by the lexer testbench: none of its own beyond the block's.
// Depends on stl_pkg; the channel interfaces come from hdl/stl_if.sv.
package stl_tb_pkg;
	import stl_pkg::*;

	// Expected token fields as checked at the output channel
	typedef struct {
		kind_t       kind;
		logic [31:0] start;
		logic [31:0] length;
		logic [23:0] line;
		logic [31:0] number;
		logic        last;
	} exp_tok_t;
endpackage

// ===== dv/script_token_lexer_core_tb.sv =====
// Testbench for script_token_lexer_core: drives script bytes, predicts the tokens
// with a behavioral lexer and checks every token transfer in order.
// Depends on stl_pkg, stl_tb_pkg, stl_if and the core.
module script_token_lexer_core_tb;
	import stl_pkg::*;
	import stl_tb_pkg::*;

	logic clk;
	logic arst_n;

	stl_byte_if  byte_ch();
	stl_token_if tok_ch();

	script_token_lexer_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_in   (byte_ch.sink),
		.token_out (tok_ch.source)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Idle probabilities in percent, changed per phase
	int unsigned send_idle_pct;
	int unsigned recv_stall_pct;
	int unsigned hold_off_cycles;
	int unsigned fail_count;
	int unsigned quiet_cycles;
	exp_tok_t    token_queue[$];

	// Predictor state
	mode_t       lx_mode;
	logic [7:0]  win[3];
	int unsigned win_n;
	logic [7:0]  held[2];
	int unsigned held_n;
	logic [31:0] cur_off;
	logic [31:0] tok_off;
	logic [23:0] cur_line;
	logic [23:0] tok_line;
	logic [31:0] tok_count;
	int unsigned run_n;

	function automatic logic dig(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic alp(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic logic wtail(input logic [7:0] c);
		return alp(c) || dig(c) || c == CH_US || c == CH_MINUS || c == CH_COLON ||
			c == CH_PLUS || c == CH_HASH || c == CH_BANG || c == CH_STAR;
	endfunction

	task automatic report_mismatch(input string what);
		$display("MISMATCH %0t: %s", $time, what);
		fail_count++;
	endtask

	function automatic void lexer_reset();
		lx_mode = M_START;
		held_n = 0;
		held[0] = 8'h00;
		held[1] = 8'h00;
		cur_off = 0;
		tok_off = 0;
		cur_line = 1;
		tok_line = 1;
		tok_count = 0;
	endfunction

	function automatic void consume(input int unsigned k);
		while (k > 0 && win_n > 0) begin
			if (cur_off != 32'hFFFF_FFFF)
				cur_off++;
			win[0] = win[1];
			win[1] = win[2];
			win_n--;
			k--;
		end
	endfunction

	function automatic void bump_line();
		if (cur_line != 24'hFF_FFFF)
			cur_line++;
	endfunction

	function automatic void push_token(input kind_t k);
		exp_tok_t t;
		lx_mode = M_START;
		if (run_n >= MAX_RESULTS)
			return;
		t.kind = k;
		t.start = tok_off;
		t.length = (k == K_END) ? 32'd0 : cur_off - tok_off;
		t.line = tok_line;
		t.number = tok_count;
		t.last = 1'b0;
		token_queue.insert(token_queue.size(), t);
		run_n++;
		if (tok_count != 32'hFFFF_FFFF)
			tok_count++;
	endfunction

	// One lexing decision; returns 0 when more lookahead is needed
	function automatic bit lex_decide();
		logic [7:0] c;
		c = win[0];
		case (lx_mode)
			M_START: begin
				tok_off = cur_off;
				tok_line = cur_line;
				if (c == CH_NUL) begin
					push_token(K_END);
					win_n = 0;
					cur_off = 0;
					tok_off = 0;
					cur_line = 1;
					tok_line = 1;
					tok_count = 0;
				end else if (c == CH_STAR) begin
					consume(1); lx_mode = M_COMMENT;
				end else if (c == CH_LF) begin
					consume(1); bump_line(); push_token(K_NEWLINE);
				end else if (c == CH_CR) begin
					if (win_n < 2) return 0;
					if (win[1] == CH_LF) begin
						consume(2); bump_line(); push_token(K_NEWLINE);
					end else begin
						consume(1); lx_mode = M_SPACE;
					end
				end else if (c == CH_SP || c == CH_TAB) begin
					consume(1); lx_mode = M_SPACE;
				end else if (c == CH_DOT) begin
					if (win_n < 2) return 0;
					if (dig(win[1])) begin
						consume(2); lx_mode = M_FRAC;
					end else begin
						consume(1); push_token(K_ERROR);
					end
				end else if (c == CH_MINUS) begin
					if (win_n < 2) return 0;
					if (win[1] == CH_DOT) begin
						if (win_n < 3) return 0;
						if (dig(win[2])) begin
							consume(3); lx_mode = M_FRAC;
						end else begin
							consume(1); push_token(K_ERROR);
						end
					end else if (dig(win[1])) begin
						consume(1); lx_mode = M_INT;
					end else begin
						consume(1); push_token(K_ERROR);
					end
				end else if (dig(c)) begin
					if (win_n < 2) return 0;
					consume(1);
					if (!alp(win[0])) lx_mode = M_INT;
					else push_token(K_ERROR);
				end else if (c == CH_PCT) begin
					if (win_n < 2) return 0;
					consume(1);
					if (win[0] == CH_ZERO || win[0] == CH_ONE) lx_mode = M_BIN;
					else push_token(K_ERROR);
				end else if (c == CH_DQ) begin
					consume(1); lx_mode = M_STR;
				end else if (c == CH_LBR) begin
					consume(1); lx_mode = M_BYTES;
				end else if (c == CH_SQ) begin
					consume(1); lx_mode = M_CH_OPEN;
				end else if (c == CH_COMMA) begin
					consume(1); push_token(K_COMMA);
				end else if (c == CH_LT || c == CH_GT) begin
					if (win_n < 2) return 0;
					if (win[1] == CH_EQ || (c == CH_LT && win[1] == CH_GT)) consume(2);
					else consume(1);
					push_token(K_WORD);
				end else if (c == CH_EQ) begin
					consume(1); push_token(K_WORD);
				end else if (alp(c)) begin
					consume(1); lx_mode = M_WORD;
				end else if (c == CH_US) begin
					if (win_n < 2) return 0;
					consume(1);
					if (alp(win[0])) lx_mode = M_WORD;
					else push_token(K_ERROR);
				end else begin
					consume(1); push_token(K_ERROR);
				end
			end
			M_COMMENT: begin
				if (c == CH_NUL || c == CH_LF) begin
					push_token(K_COMMENT);
					return 1;
				end
				if (c == CH_CR) begin
					if (win_n < 2) return 0;
					if (win[1] == CH_LF) begin
						push_token(K_COMMENT);
						return 1;
					end
				end
				consume(1);
			end
			M_SPACE: begin
				if (c == CH_SP || c == CH_TAB) begin
					consume(1);
					return 1;
				end
				if (c == CH_CR) begin
					if (win_n < 2) return 0;
					if (win[1] != CH_LF) begin
						consume(1);
						return 1;
					end
				end
				push_token(K_SPACE);
			end
			M_INT: begin
				if (dig(c)) consume(1);
				else if (c == CH_DOT) begin
					consume(1); lx_mode = M_FRAC;
				end else push_token(K_INT);
			end
			M_FRAC: begin
				if (dig(c)) consume(1);
				else push_token(K_FLOAT);
			end
			M_BIN: begin
				if (c == CH_ZERO || c == CH_ONE) consume(1);
				else push_token(K_BINARY);
			end
			M_STR: begin
				if (c == CH_NUL || c == CH_CR || c == CH_LF) push_token(K_ERROR);
				else if (c == CH_BSL) begin
					consume(1); lx_mode = M_STR_ESC;
				end else if (c == CH_DQ) begin
					consume(1); push_token(K_STRING);
				end else consume(1);
			end
			M_STR_ESC: begin
				if (c == CH_NUL) push_token(K_ERROR);
				else begin
					consume(1); lx_mode = M_STR;
				end
			end
			M_BYTES: begin
				if (c == CH_NUL) push_token(K_ERROR);
				else if (c == CH_CR || c == CH_LF) begin
					consume(1); push_token(K_ERROR);
				end else if (c == CH_RBR) begin
					consume(1); push_token(K_BYTESTR);
				end else consume(1);
			end
			M_CH_OPEN: begin
				if (c == CH_BSL) begin
					consume(1); lx_mode = M_CH_ESC;
				end else if (c == CH_NUL) push_token(K_ERROR);
				else begin
					consume(1); lx_mode = M_CH_GOT;
				end
			end
			M_CH_ESC: begin
				if (c == CH_NUL) push_token(K_ERROR);
				else begin
					consume(1); lx_mode = M_CH_GOT;
				end
			end
			M_CH_GOT: begin
				if (c == CH_NUL) push_token(K_ERROR);
				else if (c == CH_SQ) begin
					consume(1); push_token(K_CHAR);
				end else begin
					consume(1); push_token(K_ERROR);
				end
			end
			M_WORD: begin
				if (wtail(c)) consume(1);
				else push_token(K_WORD);
			end
			default: lx_mode = M_START;
		endcase
		return 1;
	endfunction

	// Predict the tokens released by one accepted byte
	function automatic void lex_byte(input logic [7:0] b);
		win_n = held_n;
		win[0] = held[0];
		win[1] = held[1];
		win[win_n] = b;
		win_n++;
		run_n = 0;
		while (win_n > 0 && run_n < MAX_RESULTS) begin
			if (!lex_decide())
				break;
		end
		if (run_n > 0)
			token_queue[token_queue.size() - 1].last = 1'b1;
		if (win_n > 2)
			win_n = 2;
		held_n = win_n;
		held[0] = win_n > 0 ? win[0] : 8'h00;
		held[1] = win_n > 1 ? win[1] : 8'h00;
	endfunction

	// Offer one byte and hold it until the transfer; valid stays up afterwards
	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(99, 0) < send_idle_pct) begin
			byte_ch.valid <= 1'b0;
			@(posedge clk);
		end
		byte_ch.valid <= 1'b1;
		byte_ch.in_byte <= b;
		@(posedge clk);
		while (!byte_ch.ready)
			@(posedge clk);
		lex_byte(b);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i]);
	endtask

	// Drop valid, then wait for every predicted token
	task automatic wait_drained();
		byte_ch.valid <= 1'b0;
		while (token_queue.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// Receiver: random stalls plus an optional long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_ch.ready <= 1'b0;
		end else if (hold_off_cycles > 0) begin
			hold_off_cycles <= hold_off_cycles - 1;
			tok_ch.ready <= 1'b0;
		end else begin
			tok_ch.ready <= ($urandom_range(99, 0) >= recv_stall_pct);
		end
	end

	// Check every token transfer against the oldest prediction
	always @(posedge clk) begin
		exp_tok_t e;
		if (arst_n && tok_ch.valid && tok_ch.ready) begin
			if (token_queue.size() == 0) begin
				report_mismatch("token with no prediction");
			end else begin
				e = token_queue.pop_front();
				if (tok_ch.token_kind != e.kind)
					report_mismatch($sformatf("kind %0d want %0d", tok_ch.token_kind, e.kind));
				if (tok_ch.token_start != e.start)
					report_mismatch($sformatf("start %0d want %0d", tok_ch.token_start, e.start));
				if (tok_ch.token_length != e.length)
					report_mismatch($sformatf("length %0d want %0d", tok_ch.token_length,
						e.length));
				if (tok_ch.token_line != e.line)
					report_mismatch($sformatf("line %0d want %0d", tok_ch.token_line, e.line));
				if (tok_ch.token_number != e.number)
					report_mismatch($sformatf("number %0d want %0d", tok_ch.token_number,
						e.number));
				if (tok_ch.last_of_run != e.last)
					report_mismatch($sformatf("last %0b want %0b", tok_ch.last_of_run, e.last));
			end
		end
	end

	// Watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((byte_ch.valid && byte_ch.ready) || (tok_ch.valid && tok_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > 20000) begin
			$display("simulation failed");
			$finish;
		end
	end

	// Directed scripts cover every token kind and the end-of-script cases
	task automatic test_directed();
		send_text("* note\n12 -7 3.5 .5 -.25 %1011 \"a\\\"b\" [12 ab] 'x' '\\n' ,");
		send_text("\r\n<> <= >= < > = word_1 _ab 9a %x _1 ~ \t\r x \xff\x01");
		send_byte(CH_NUL);
		send_text("\"ab\\"); send_byte(CH_NUL);
		send_text("[ab"); send_byte(CH_NUL);
		send_text("[a\nb] \"x\n\"y\r '\n' '\r"); send_byte(CH_NUL);
		send_text("-.x -a . -"); send_byte(CH_NUL);
		send_text("*c\r\n' '\\"); send_byte(CH_NUL);
	endtask

	function automatic logic [7:0] pick_byte();
		logic [7:0] menu[24] = '{"*", "\n", "\r", " ", "\t", ".", "-", "0", "1", "7",
			"%", "\"", "\\", "[", "]", "'", ",", "<", ">", "=", "a", "Z", "_", "x"};
		case ($urandom_range(9, 0))
			0: return 8'($urandom_range(255, 1));
			1: return ($urandom_range(19, 0) == 0) ? CH_NUL : menu[5'($urandom_range(23, 0))];
			default: return menu[5'($urandom_range(23, 0))];
		endcase
	endfunction

	task automatic test_random(input int unsigned n, input int unsigned s_pct,
		input int unsigned r_pct);
		send_idle_pct = s_pct;
		recv_stall_pct = r_pct;
		for (int unsigned i = 0; i < n; i++)
			send_byte(pick_byte());
	endtask

	// Long receiver hold-off while bytes keep coming, so the input stalls
	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_off_cycles = 300;
		send_text(", , ; a b 1 2");
		wait_drained();
	endtask

	initial begin
		arst_n = 1'b0;
		byte_ch.valid = 1'b0;
		byte_ch.in_byte = 8'h00;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_off_cycles = 0;
		fail_count = 0;
		quiet_cycles = 0;
		lexer_reset();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		wait_drained();
		test_backpressure();
		test_random(90, 0, 0);
		test_random(70, 76, 0);
		wait_drained();
		test_random(70, 0, 76);
		test_random(64, 11, 11);
		send_byte(CH_NUL);
		wait_drained();
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule
